// ----- rtl/cst_pkg.sv -----
package cst_pkg;

	localparam int ID_W    = 11;
	localparam int START_W = 6;
	localparam int LEN_W   = 6;
	localparam int VALUE_W = 32;
	localparam int SLOT_W  = 4;
	localparam int DATA_W  = 64;
	localparam int DFLT_SLOTS = 16;

	// request codes
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_FRAME  = 2'd1;
	localparam logic [1:0] REQ_REPORT = 2'd2;

	// one table slot as held by a cell
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [START_W-1:0] start_bit;
		logic [LEN_W-1:0]   length;
		logic [VALUE_W-1:0] value;
		logic               fresh;
	} slot_t;

	localparam logic [ID_W-1:0] DFLT_ID [DFLT_SLOTS] = '{
		11'h360, 11'h360, 11'h361, 11'h3E0, 11'h390, 11'h390, 11'h390, 11'h390,
		11'h370, 11'h3E0, 11'h373, 11'h368, 11'h3EB, 11'h000, 11'h000, 11'h000
	};
	localparam logic [START_W-1:0] DFLT_START [DFLT_SLOTS] = '{
		6'd0, 6'd32, 6'd16, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd0, 6'd48, 6'd0, 6'd0, 6'd32, 6'd0, 6'd0, 6'd0
	};
	localparam logic [LEN_W-1:0] DFLT_LEN [DFLT_SLOTS] = '{
		6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd16,
		6'd16, 6'd16, 6'd16, 6'd16, 6'd16, 6'd0, 6'd0, 6'd0
	};

	function automatic logic [ID_W-1:0] dflt_id(input int i);
		logic [ID_W-1:0] r;
		r = '0;
		if (i < DFLT_SLOTS) r = DFLT_ID[i[3:0]];
		return r;
	endfunction

	function automatic logic [START_W-1:0] dflt_start(input int i);
		logic [START_W-1:0] r;
		r = '0;
		if (i < DFLT_SLOTS) r = DFLT_START[i[3:0]];
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] dflt_len(input int i);
		logic [LEN_W-1:0] r;
		r = '0;
		if (i < DFLT_SLOTS) r = DFLT_LEN[i[3:0]];
		return r;
	endfunction

	// byte idx of the frame payload, zero past byte 7
	function automatic logic [7:0] frame_byte(input logic [DATA_W-1:0] data,
			input logic [3:0] idx);
		logic [7:0] b;
		b = '0;
		if (idx < 4'd8) b = data[{idx[2:0], 3'b000} +: 8];
		return b;
	endfunction

endpackage

// ----- rtl/can_signal_table_extractor.sv -----
// CAN signal table extractor.
// Command channel: an item (req_type plus its fields) transfers at a rising
// edge with start high and busy low.
//   table write  - loads slot_index with id/start/length, clears its fresh
//                  flag; busy stays low.
//   CAN frame    - busy while the table rotates once through the shared
//                  extractor; matching slots with a nonzero id take the new
//                  value and turn fresh. No result.
//   report       - busy while the table rotates once; one result transfer
//                  per slot, in slot order, marked by report_valid, the
//                  first registered from the report state, report_last on
//                  the final slot. Fresh flags clear as slots are reported.
// A new frame or report item is taken only once the previous pass is over;
// while busy the ring of slot cells moves one slot past the extractor per cycle.
// Results are valid for exactly one cycle and the receiver cannot stall.
// Reset (arst_n low) loads the default table, zero values, all stale.
module can_signal_table_extractor #(
	parameter int SLOT_COUNT      = 16,
	parameter int MAX_SIGNAL_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [3:0]  slot_index,
	input  logic [10:0] slot_can_id,
	input  logic [5:0]  slot_start_bit,
	input  logic [5:0]  slot_length,
	input  logic [10:0] frame_id,
	input  logic [63:0] frame_data,
	output logic        report_valid,
	output logic [3:0]  report_slot,
	output logic [31:0] report_value,
	output logic        report_fresh,
	output logic        report_last
);

	localparam int CW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [CW-1:0] LAST_POS = CW'(SLOT_COUNT - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FRAME  = 2'd1;
	localparam logic [1:0] ST_REPORT = 2'd2;

	logic [1:0]     state_q;
	logic [CW-1:0]  pos_q;
	logic [10:0]    frame_id_q;
	logic [63:0]    frame_data_q;

	logic           accept;
	logic           wr_en;
	logic           rotate;
	logic           pos_last;

	cst_pkg::slot_t cell_out [SLOT_COUNT];
	cst_pkg::slot_t head;
	cst_pkg::slot_t tail_in;
	logic [31:0]    ext_value;
	logic           hit;

	logic           report_valid_q;
	logic [3:0]     report_slot_q;
	logic [31:0]    report_value_q;
	logic           report_fresh_q;
	logic           report_last_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign wr_en    = accept && (req_type == cst_pkg::REQ_WRITE);
	assign rotate   = busy;
	assign pos_last = (pos_q == LAST_POS);

	// slot 0 sits at the head of the ring; it leaves through the extractor
	// and re-enters at the tail, so after a full turn of the ring the order is back.
	assign head = cell_out[0];

	cst_extract #(
		.MAX_SIGNAL_BITS(MAX_SIGNAL_BITS)
	) u_extract (
		.data      (frame_data_q),
		.start_bit (head.start_bit),
		.length    (head.length),
		.value     (ext_value)
	);

	assign hit = (head.id != 11'd0) && (head.id == frame_id_q);

	always_comb begin
		tail_in = head;
		unique case (state_q)
			ST_FRAME: begin
				if (hit) begin
					tail_in.value = ext_value;
					tail_in.fresh = 1'b1;
				end
			end
			ST_REPORT: begin
				tail_in.fresh = 1'b0;
			end
			default: begin
				tail_in = head;
			end
		endcase
	end

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		cst_pkg::slot_t nb;
		if (i == SLOT_COUNT - 1) begin : g_tail
			assign nb = tail_in;
		end else begin : g_mid
			assign nb = cell_out[i + 1];
		end
		cst_cell #(
			.ID_RST    (cst_pkg::dflt_id(i)),
			.START_RST (cst_pkg::dflt_start(i)),
			.LEN_RST   (cst_pkg::dflt_len(i))
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (rotate),
			.shift_in   (nb),
			// slot indexes at or above SLOT_COUNT hit no cell
			.load_en    (wr_en && ({3'b000, slot_index} == 7'(i))),
			.load_id    (slot_can_id),
			.load_start (slot_start_bit),
			.load_len   (slot_length),
			.slot       (cell_out[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (accept && req_type == cst_pkg::REQ_FRAME) begin
						state_q <= ST_FRAME;
					end else if (accept && req_type == cst_pkg::REQ_REPORT) begin
						state_q <= ST_REPORT;
					end
				end
				ST_FRAME, ST_REPORT: begin
					pos_q <= pos_q + CW'(1);
					if (pos_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// frame held for the whole pass
	always_ff @(posedge clk) begin
		if (accept && req_type == cst_pkg::REQ_FRAME) begin
			frame_id_q   <= frame_id;
			frame_data_q <= frame_data;
		end
	end

	// result register: head slot of each report cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else begin
			report_valid_q <= (state_q == ST_REPORT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REPORT) begin
			report_slot_q  <= 4'(pos_q);
			report_value_q <= head.value;
			report_fresh_q <= head.fresh;
			report_last_q  <= pos_last;
		end
	end

	assign report_valid = report_valid_q;
	assign report_slot  = report_slot_q;
	assign report_value = report_value_q;
	assign report_fresh = report_fresh_q;
	assign report_last  = report_last_q;

	// a result only follows a report cycle
	a_valid_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> $past(state_q == ST_REPORT))
		else $error("result transfer outside a report run");

	// final result carries the last slot number
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report_last) |-> (report_slot == 4'(SLOT_COUNT - 1)))
		else $error("report_last on wrong slot");

	// a report run has no gaps
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && !report_last) |=> report_valid)
		else $error("report run interrupted");

endmodule

// ----- rtl/cst_cell.sv -----
module cst_cell #(
	parameter logic [10:0] ID_RST    = 11'd0,
	parameter logic [5:0]  START_RST = 6'd0,
	parameter logic [5:0]  LEN_RST   = 6'd0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  cst_pkg::slot_t    shift_in,
	input  logic              load_en,
	input  logic [10:0]       load_id,
	input  logic [5:0]        load_start,
	input  logic [5:0]        load_len,
	output cst_pkg::slot_t    slot
);

	cst_pkg::slot_t slot_q;

	// load keeps the value, clears fresh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q.id        <= ID_RST;
			slot_q.start_bit <= START_RST;
			slot_q.length    <= LEN_RST;
			slot_q.value     <= '0;
			slot_q.fresh     <= 1'b0;
		end else if (load_en) begin
			slot_q.id        <= load_id;
			slot_q.start_bit <= load_start;
			slot_q.length    <= load_len;
			slot_q.fresh     <= 1'b0;
		end else if (shift_en) begin
			slot_q <= shift_in;
		end
	end

	assign slot = slot_q;

endmodule

// ----- rtl/cst_extract.sv -----
module cst_extract #(
	parameter int MAX_SIGNAL_BITS = 32
) (
	input  logic [63:0] data,
	input  logic [5:0]  start_bit,
	input  logic [5:0]  length,
	output logic [31:0] value
);

	localparam logic [5:0] MAX_LEN = 6'(MAX_SIGNAL_BITS);

	logic [5:0]  len_c;
	logic [2:0]  nbytes;
	logic [3:0]  rem;
	logic [31:0] mask;
	logic [31:0] acc;
	logic [7:0]  b;
	logic [7:0]  part;
	logic [5:0]  sh;

	always_comb begin
		len_c  = (length > MAX_LEN) ? MAX_LEN : length;
		nbytes = 3'((7'(len_c) + 7'd7) >> 3);
		rem    = 4'(7'(len_c) - 7'({nbytes, 3'b000}) + 7'd8);
		mask   = (32'd1 << rem) - 32'd1;
		acc    = '0;
		b      = '0;
		part   = '0;
		sh     = '0;
		for (int k = 0; k < 4; k++) begin
			b = cst_pkg::frame_byte(data, 4'(start_bit[5:3]) + 4'(k));
			if (3'(k + 1) < nbytes) begin
				// whole byte, big-endian above the later ones
				sh  = len_c - 6'(8 * (k + 1));
				acc = acc | (32'(b) << sh);
			end else if (3'(k + 1) == nbytes) begin
				part = b >> start_bit[2:0];
				acc  = acc | (32'(part) & mask);
			end
		end
		value = (len_c == 6'd0) ? 32'd0 : acc;
	end

endmodule
